// ===== src/ovt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ovt_pkg;
  localparam int unsigned Depth = 256;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW = AddrW + 1;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_ERASE  = 3'd3,
    REQ_REMOVE = 3'd4,
    REQ_READ   = 3'd5,
    REQ_CLEAR  = 3'd6,
    REQ_SORT   = 3'd7
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_RDW,
    ST_INS_RD,
    ST_INS_WR,
    ST_SH_RD,
    ST_SH_WR,
    ST_SRCH,
    ST_SO_KEY,
    ST_SO_CMP,
    ST_SO_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [CntW-1:0]   position;
    logic signed [31:0] item_value;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic signed [31:0] read_value;
    logic [CntW-1:0]   entry_count;
  } rsp_t;
endpackage
`default_nettype wire

// ===== src/ovt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ovt_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [31:0]      wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic [31:0]           rdata_o
);
  logic [31:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/ordered_vector_table_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                     when taken
// request   start_i, req_i, busy_o    start_i & !busy_o
// result    done_o, rsp_o             done_o, one cycle
// push, clear and refusals other than remove: straight to the result; pop, read: a read and a read-wait state
// insert, erase: a read and a write state per entry moved; remove: a search state per entry searched, then as erase
// sort: insertion sort, key, compare and write states per key plus a further write state per entry moved
// all loops run through one single-port-write ram with registered read
// reset clears the state and the count only; no clearing pass over the ram
// results cannot be stalled
module ordered_vector_table_engine import ovt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output rsp_t      rsp_o
);
  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  req_t req_q, req_d;
  logic [31:0] key_q, key_d;
  logic ok_q, ok_d;
  logic [31:0] rv_q, rv_d;
  logic we;
  logic [AddrW-1:0] wa, ra;
  logic [31:0] wd, rdata;

  ovt_ram #(.Depth(Depth), .AddrW(AddrW)) u_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rdata)
  );

  function automatic logic sless(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; req_q <= req_d; key_q <= key_d;
    ok_q <= ok_d; rv_q <= rv_d;
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q;
    req_d = req_q; key_d = key_q; ok_d = ok_q; rv_d = rv_q;
    we = 1'b0; wa = i_q[AddrW-1:0]; wd = key_q; ra = i_q[AddrW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          req_d = req_i; ok_d = 1'b0; rv_d = '0;
          key_d = req_i.item_value;
          state_d = ST_DONE;
          case (req_e'(req_i.req_type))
            REQ_PUSH: begin
              if (cnt_q < CntW'(Depth)) begin
                we = 1'b1; wa = cnt_q[AddrW-1:0]; wd = req_i.item_value;
                cnt_d = cnt_q + 1'b1; ok_d = 1'b1;
              end
            end
            REQ_POP: begin
              if (cnt_q != '0) begin
                i_d = cnt_q - 1'b1; cnt_d = cnt_q - 1'b1; ok_d = 1'b1;
                state_d = ST_RD;
              end
            end
            REQ_READ: begin
              if (req_i.position < cnt_q) begin
                i_d = req_i.position; ok_d = 1'b1; state_d = ST_RD;
              end
            end
            REQ_INSERT: begin
              if (cnt_q < CntW'(Depth) && req_i.position <= cnt_q) begin
                i_d = cnt_q; ok_d = 1'b1; state_d = ST_INS_RD;
              end
            end
            REQ_ERASE: begin
              if (req_i.position < cnt_q) begin
                i_d = req_i.position; ok_d = 1'b1; state_d = ST_SH_RD;
              end
            end
            REQ_REMOVE: begin
              i_d = '0;
              if (cnt_q != '0) begin
                state_d = ST_SRCH;
              end
            end
            REQ_CLEAR: begin
              cnt_d = '0; ok_d = 1'b1;
            end
            default: begin
              ok_d = 1'b1; i_d = CntW'(1);
              if (cnt_q > CntW'(1)) begin
                state_d = ST_SO_KEY;
              end
            end
          endcase
        end
      end
      ST_RD: state_d = ST_RDW;
      ST_RDW: begin
        rv_d = rdata; state_d = ST_DONE;
      end
      ST_INS_RD: begin
        if (i_q == req_q.position) begin
          we = 1'b1; wd = req_q.item_value;
          cnt_d = cnt_q + 1'b1; state_d = ST_DONE;
        end else begin
          ra = AddrW'(i_q - 1'b1); state_d = ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        we = 1'b1; wd = rdata; i_d = i_q - 1'b1; state_d = ST_INS_RD;
      end
      ST_SH_RD: begin
        if (i_q + 1'b1 >= cnt_q) begin
          cnt_d = cnt_q - 1'b1; state_d = ST_DONE;
        end else begin
          ra = AddrW'(i_q + 1'b1); state_d = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        we = 1'b1; wd = rdata; i_d = i_q + 1'b1; state_d = ST_SH_RD;
      end
      ST_SRCH: begin
        // read of entry i_q is issued here, rdata holds entry i_q - 1
        if (i_q != '0 && rdata == req_q.item_value) begin
          ok_d = 1'b1; i_d = i_q - 1'b1; state_d = ST_SH_RD;
        end else if (i_q == cnt_q) begin
          state_d = ST_DONE;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_SO_KEY: begin
        if (i_q >= cnt_q) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SO_CMP; j_d = i_q;
        end
      end
      ST_SO_CMP: begin
        // rdata holds entry i_q on entry; then entry j-1
        state_d = ST_SO_WR;
        ra = AddrW'(j_q - 1'b1);
        if (j_q == i_q) begin
          key_d = rdata;
        end
      end
      ST_SO_WR: begin
        if (j_q != '0 && sless(key_q, rdata)) begin
          we = 1'b1; wa = j_q[AddrW-1:0]; wd = rdata;
          j_d = j_q - 1'b1;
          ra = AddrW'(j_q - 2'd2);
          if (j_q == CntW'(1)) begin
            state_d = ST_SO_WR;
          end
        end else begin
          we = 1'b1; wa = j_q[AddrW-1:0]; wd = key_q;
          i_d = i_q + 1'b1; ra = AddrW'(i_q + 1'b1);
          state_d = ST_SO_KEY;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (state_q == ST_SO_KEY) begin
      ra = i_q[AddrW-1:0];
    end
    if (state_q == ST_SRCH) begin
      ra = i_q[AddrW-1:0];
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  assign rsp_o  = '{ok: ok_q, read_value: rv_q, entry_count: cnt_q};

  property p_done_busy;
    @(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_o;
  endproperty
  a_done_busy: assert property (p_done_busy) else $error("done while idle");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("count over depth");
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !start_i) |=> $stable(cnt_q)) else $error("count moved while idle");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result");
endmodule
`default_nettype wire

// ===== tb/ordered_vector_table_engine_tb.sv =====
`timescale 1ns / 1ps
module ordered_vector_table_engine_tb;
  import ovt_pkg::*;

  localparam int unsigned CycleLimit = 4000000;

  typedef struct {
    req_e              op;
    int unsigned       pos;
    logic signed [31:0] val;
    bit                typed;
    rsp_t              rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  logic signed [31:0] vec_words [Depth];
  int unsigned vec_count = 0;
  rsp_t pending_rsp [$];
  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int sorts_sent = 0;
  int refused_seen = 0;
  int peak_count = 0;
  int unsigned cycles = 0;
  bit idle_on = 1'b1;

  ordered_vector_table_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout with %0d words outstanding", $time, pending_rsp.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < vec_count; i++) vec_words[i] = vec_words[i + 1];
    vec_count--;
  endfunction

  function automatic rsp_t vector_step(req_t r);
    rsp_t o;
    logic signed [31:0] key;
    int j;
    o = '0;
    case (req_e'(r.req_type))
      REQ_PUSH: if (vec_count < Depth) begin
        vec_words[vec_count] = r.item_value;
        vec_count++;
        o.ok = 1'b1;
      end
      REQ_POP: if (vec_count > 0) begin
        vec_count--;
        o.read_value = vec_words[vec_count];
        o.ok = 1'b1;
      end
      REQ_INSERT: if (vec_count < Depth && r.position <= vec_count) begin
        for (int unsigned i = vec_count; i > r.position; i--) vec_words[i] = vec_words[i - 1];
        vec_words[r.position] = r.item_value;
        vec_count++;
        o.ok = 1'b1;
      end
      REQ_ERASE: if (r.position < vec_count) begin
        drop_entry(r.position);
        o.ok = 1'b1;
      end
      REQ_REMOVE: begin
        for (int unsigned i = 0; i < vec_count; i++) begin
          if (vec_words[i] == r.item_value) begin
            drop_entry(i);
            o.ok = 1'b1;
            break;
          end
        end
      end
      REQ_READ: if (r.position < vec_count) begin
        o.read_value = vec_words[r.position];
        o.ok = 1'b1;
      end
      REQ_CLEAR: begin
        vec_count = 0;
        o.ok = 1'b1;
      end
      default: begin
        for (int i = 1; i < int'(vec_count); i++) begin
          key = vec_words[i];
          j = i;
          while (j > 0 && key < vec_words[j - 1]) begin
            vec_words[j] = vec_words[j - 1];
            j--;
          end
          vec_words[j] = key;
        end
        o.ok = 1'b1;
      end
    endcase
    o.entry_count = vec_count[CntW-1:0];
    return o;
  endfunction

  task automatic send_word(req_e op, int unsigned pos, logic signed [31:0] val,
                           bit typed = 1'b0, rsp_t typed_rsp = '0);
    req_t r;
    rsp_t predicted;
    r.req_type = op;
    r.position = pos[CntW-1:0];
    r.item_value = val;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predicted = vector_step(r);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    words_sent++;
    if (op == REQ_SORT) sorts_sent++;
    if (vec_count > peak_count) peak_count = vec_count;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      words_seen++;
      if (!rsp_o.ok) refused_seen++;
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected word: actual %0d/%0d/%0d", $time,
                 rsp_o.ok, rsp_o.read_value, rsp_o.entry_count);
        errors++;
      end else begin
        if (rsp_o.ok !== pending_rsp[0].ok || rsp_o.read_value !== pending_rsp[0].read_value ||
            rsp_o.entry_count !== pending_rsp[0].entry_count) begin
          $display({"%0t mismatch: expected ok=%0d value=%0d count=%0d, ",
                    "actual ok=%0d value=%0d count=%0d"},
                   $time, pending_rsp[0].ok, pending_rsp[0].read_value,
                   pending_rsp[0].entry_count, rsp_o.ok, rsp_o.read_value,
                   rsp_o.entry_count);
          errors++;
        end
        void'(pending_rsp.pop_front());
      end
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return $signed(32'($urandom_range(0, 15)) - 32'd8);
      5: return (vec_count > 0) ? vec_words[$urandom_range(0, vec_count - 1)] : 32'sd5;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic int unsigned pick_pos();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, Depth);
      1: return vec_count;
      2: return Depth;
      default: return (vec_count > 0) ? $urandom_range(0, vec_count - 1) : 0;
    endcase
  endfunction

  task automatic random_word(int unsigned count_cap);
    req_e op;
    int unsigned w;
    w = $urandom_range(0, 99);
    if (vec_count > count_cap && w < 50) op = (w < 3) ? REQ_CLEAR : REQ_POP;
    else if (w < 26) op = REQ_PUSH;
    else if (w < 36) op = REQ_POP;
    else if (w < 52) op = REQ_INSERT;
    else if (w < 62) op = REQ_ERASE;
    else if (w < 72) op = REQ_REMOVE;
    else if (w < 88) op = REQ_READ;
    else if (w < 91) op = REQ_CLEAR;
    else op = REQ_SORT;
    send_word(op, pick_pos(), pick_value());
  endtask

  stim_row_t table_rows [] = '{
    '{REQ_POP,    0, 32'sd0,        1'b1, '{1'b0, 32'sd0, 9'd0}},
    '{REQ_READ,   0, 32'sd0,        1'b1, '{1'b0, 32'sd0, 9'd0}},
    '{REQ_ERASE,  0, 32'sd0,        1'b1, '{1'b0, 32'sd0, 9'd0}},
    '{REQ_REMOVE, 0, 32'sd0,        1'b1, '{1'b0, 32'sd0, 9'd0}},
    '{REQ_SORT,   0, 32'sd0,        1'b1, '{1'b1, 32'sd0, 9'd0}},
    '{REQ_PUSH,   0, 32'sh7fffffff, 1'b1, '{1'b1, 32'sd0, 9'd1}},
    '{REQ_PUSH,   0, 32'sh80000000, 1'b1, '{1'b1, 32'sd0, 9'd2}},
    '{REQ_INSERT, 0, -32'sd1,       1'b1, '{1'b1, 32'sd0, 9'd3}},
    '{REQ_INSERT, 256, 32'sd9,      1'b1, '{1'b0, 32'sd0, 9'd3}},
    '{REQ_INSERT, 3, 32'sd0,        1'b1, '{1'b1, 32'sd0, 9'd4}},
    '{REQ_READ,   1, 32'sd0,        1'b1, '{1'b1, 32'sh7fffffff, 9'd4}},
    '{REQ_READ,   4, 32'sd0,        1'b1, '{1'b0, 32'sd0, 9'd4}},
    '{REQ_SORT,   0, 32'sd0,        1'b0, '0},
    '{REQ_READ,   0, 32'sd0,        1'b1, '{1'b1, 32'sh80000000, 9'd4}},
    '{REQ_READ,   3, 32'sd0,        1'b1, '{1'b1, 32'sh7fffffff, 9'd4}},
    '{REQ_REMOVE, 0, -32'sd1,       1'b1, '{1'b1, 32'sd0, 9'd3}},
    '{REQ_REMOVE, 0, 32'sd5,        1'b1, '{1'b0, 32'sd0, 9'd3}},
    '{REQ_ERASE,  255, 32'sd0,      1'b1, '{1'b0, 32'sd0, 9'd3}},
    '{REQ_ERASE,  0, 32'sd0,        1'b1, '{1'b1, 32'sd0, 9'd2}},
    '{REQ_POP,    0, 32'sd0,        1'b0, '0},
    '{REQ_INSERT, 1, 32'sd77,       1'b0, '0},
    '{REQ_READ,   1, 32'sd0,        1'b0, '0},
    '{REQ_CLEAR,  0, 32'sd0,        1'b1, '{1'b1, 32'sd0, 9'd0}}
  };

  initial begin
    int unsigned wait_cycles;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (table_rows[i])
      send_word(table_rows[i].op, table_rows[i].pos, table_rows[i].val,
                table_rows[i].typed, table_rows[i].rsp);

    repeat (800) random_word(40);

    // fill to capacity, check the full-store refusals, one large sort
    while (vec_count < Depth - 1) send_word(REQ_PUSH, 0, pick_value());
    send_word(REQ_INSERT, Depth - 1, pick_value());
    send_word(REQ_PUSH, 0, pick_value());
    send_word(REQ_INSERT, 0, pick_value());
    send_word(REQ_READ, Depth - 1, 32'sd0);
    send_word(REQ_READ, Depth, 32'sd0);
    send_word(REQ_SORT, 0, 32'sd0);
    send_word(REQ_READ, 0, 32'sd0);
    send_word(REQ_REMOVE, 0, vec_words[Depth - 1]);
    send_word(REQ_ERASE, 0, 32'sd0);
    send_word(REQ_INSERT, 0, 32'sh80000000);
    send_word(REQ_CLEAR, 0, 32'sd0);

    idle_on = 1'b0;
    repeat (200) random_word(24);
    start_i <= 1'b0;

    wait_cycles = 0;
    while (pending_rsp.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (20) @(posedge clk_i);

    $display("%0d requests sent (%0d sorts), %0d results checked, %0d refused",
             words_sent, sorts_sent, words_seen, refused_seen);
    $display("peak entry count %0d, outstanding %0d, errors %0d",
             peak_count, pending_rsp.size(), errors);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/ovt_pkg.sv
src/ovt_ram.sv
src/ordered_vector_table_engine.sv
tb/ordered_vector_table_engine_tb.sv
